// ----- rtl/c2s_pkg.sv -----
// ----------------------------------------------------------------------------
// c2s_pkg
// Shared constants and the elaboration-time arctangent table for the
// cartesian to spherical converter.
// ----------------------------------------------------------------------------
`default_nettype none
package c2s_pkg;

	localparam int ANGLE_FRAC_BITS_DEF = 16;
	localparam int CORDIC_STEPS_DEF    = 32;
	localparam int INT_FRAC            = 40;
	localparam int GUARD_BITS          = 20;
	localparam int ROOT_STEPS          = 32;
	localparam int LANE_W              = 56;
	localparam int ANG_W               = 52;
	localparam int SIDE_W              = 33;
	localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;

	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// atan(2^-i) in units of 2^-40 degree
	function automatic logic [ANG_W-1:0] atan_entry(input int i);
		logic [63:0] a;
		logic [63:0] q;
		logic [63:0] r;
		logic [63:0] term;
		logic [63:0] prod;
		int e;
		logic stop;
		a = '0;
		q = '0;
		stop = 1'b0;
		if (i == 0) begin
			a = PI_Q60 >> 2;
		end else begin
			for (int k = 0; k < 64; k++) begin
				e = i * (2 * k + 1);
				if (e > 60) stop = 1'b1;
				if (!stop) begin
					term = udiv64(64'd1 << (60 - e), 64'(2 * k + 1));
					if (k[0]) a = a - term;
					else a = a + term;
				end
			end
		end
		r = a;
		for (int b = 0; b < 50; b++) begin
			r = r << 1;
			q = q << 1;
			if (r >= PI_Q60) begin
				r = r - PI_Q60;
				q = q | 64'd1;
			end
		end
		prod = (q * 64'd180 + 64'd512) >> 10;
		return prod[ANG_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ----- rtl/c2s_front.sv -----
// ----------------------------------------------------------------------------
// c2s_front
// Magnitudes, squares, sums and operand normalization, five register stages.
// ----------------------------------------------------------------------------
`default_nettype none
module c2s_front import c2s_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	input  wire logic signed [31:0]       pos_x,
	input  wire logic signed [31:0]       pos_y,
	input  wire logic signed [31:0]       pos_z,
	input  wire logic signed [31:0]       vel_x,
	input  wire logic signed [31:0]       vel_y,
	input  wire logic signed [31:0]       vel_z,
	output logic                          out_valid,
	output logic [63:0]                   pos_sum,
	output logic [63:0]                   vel_sum,
	output logic [63:0]                   rho_sum,
	output logic signed [SIDE_W-1:0]      cx,
	output logic signed [SIDE_W-1:0]      cy,
	output logic signed [SIDE_W-1:0]      sz,
	output logic                          neg_x,
	output logic                          xy_zero
);

	function automatic logic [4:0] norm_shift(input logic [31:0] m);
		logic [4:0] k;
		logic [4:0] s;
		k = '0;
		for (int b = 0; b < 32; b++) begin
			if (m[b]) k = 5'(b);
		end
		if (m == '0) s = '0;
		else if ((m & (m - 32'd1)) == '0) s = 5'(31) - k;
		else s = 5'(30) - k;
		return s;
	endfunction

	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [31:0] ax_s1, ay_s1, az_s1, avx_s1, avy_s1, avz_s1;
	logic signed [31:0] x_s1, y_s1, z_s1;
	logic [63:0] px_s2, py_s2, pz_s2, vx_s2, vy_s2, vz_s2;
	logic [4:0]  sra_s2, sdec_s2;
	logic [31:0] ax_s2, ay_s2;
	logic signed [31:0] x_s2, y_s2, z_s2;
	logic [63:0] pos_s3, vel_s3;
	logic [31:0] mx_s3, my_s3;
	logic signed [SIDE_W-1:0] cx_s3, cy_s3, sz_s3;
	logic        neg_s3, xyz_s3;
	logic [63:0] pos_s4, vel_s4, mxx_s4, myy_s4;
	logic signed [SIDE_W-1:0] cx_s4, cy_s4, sz_s4;
	logic        neg_s4, xyz_s4;
	logic signed [SIDE_W-1:0] cx_s5, cy_s5, sz_s5;
	logic [63:0] pos_s5, vel_s5, rho_s5;
	logic        neg_s5, xyz_s5;

	logic [31:0] m_xy, m_xyz;
	logic signed [SIDE_W-1:0] xw, yw, zw, xsh, ysh;

	always_comb begin
		m_xy  = (ax_s1 > ay_s1) ? ax_s1 : ay_s1;
		m_xyz = (az_s1 > m_xy) ? az_s1 : m_xy;
		xw    = {x_s2[31], x_s2};
		yw    = {y_s2[31], y_s2};
		zw    = {z_s2[31], z_s2};
		xsh   = xw <<< sra_s2;
		ysh   = yw <<< sra_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		// magnitudes
		ax_s1  <= pos_x[31] ? 32'(-pos_x) : 32'(pos_x);
		ay_s1  <= pos_y[31] ? 32'(-pos_y) : 32'(pos_y);
		az_s1  <= pos_z[31] ? 32'(-pos_z) : 32'(pos_z);
		avx_s1 <= vel_x[31] ? 32'(-vel_x) : 32'(vel_x);
		avy_s1 <= vel_y[31] ? 32'(-vel_y) : 32'(vel_y);
		avz_s1 <= vel_z[31] ? 32'(-vel_z) : 32'(vel_z);
		x_s1   <= pos_x;
		y_s1   <= pos_y;
		z_s1   <= pos_z;
		// squares and shift amounts
		px_s2   <= 64'(ax_s1) * 64'(ax_s1);
		py_s2   <= 64'(ay_s1) * 64'(ay_s1);
		pz_s2   <= 64'(az_s1) * 64'(az_s1);
		vx_s2   <= 64'(avx_s1) * 64'(avx_s1);
		vy_s2   <= 64'(avy_s1) * 64'(avy_s1);
		vz_s2   <= 64'(avz_s1) * 64'(avz_s1);
		sra_s2  <= norm_shift(m_xy);
		sdec_s2 <= norm_shift(m_xyz);
		ax_s2   <= ax_s1;
		ay_s2   <= ay_s1;
		x_s2    <= x_s1;
		y_s2    <= y_s1;
		z_s2    <= z_s1;
		// sums and scaling
		pos_s3 <= px_s2 + py_s2 + pz_s2;
		vel_s3 <= vx_s2 + vy_s2 + vz_s2;
		mx_s3  <= ax_s2 << sdec_s2;
		my_s3  <= ay_s2 << sdec_s2;
		sz_s3  <= zw <<< sdec_s2;
		neg_s3 <= x_s2[31];
		xyz_s3 <= (ax_s2 == '0) && (ay_s2 == '0);
		cx_s3  <= x_s2[31] ? -xsh : xsh;
		cy_s3  <= x_s2[31] ? -ysh : ysh;
		// planar squares
		mxx_s4 <= 64'(mx_s3) * 64'(mx_s3);
		myy_s4 <= 64'(my_s3) * 64'(my_s3);
		pos_s4 <= pos_s3;
		vel_s4 <= vel_s3;
		cx_s4  <= cx_s3;
		cy_s4  <= cy_s3;
		sz_s4  <= sz_s3;
		neg_s4 <= neg_s3;
		xyz_s4 <= xyz_s3;
		// planar sum
		rho_s5 <= mxx_s4 + myy_s4;
		pos_s5 <= pos_s4;
		vel_s5 <= vel_s4;
		cx_s5  <= cx_s4;
		cy_s5  <= cy_s4;
		sz_s5  <= sz_s4;
		neg_s5 <= neg_s4;
		xyz_s5 <= xyz_s4;
	end

	assign out_valid = v_s5;
	assign pos_sum   = pos_s5;
	assign vel_sum   = vel_s5;
	assign rho_sum   = rho_s5;
	assign cx        = cx_s5;
	assign cy        = cy_s5;
	assign sz        = sz_s5;
	assign neg_x     = neg_s5;
	assign xy_zero   = xyz_s5;

endmodule
`default_nettype wire

// ----- rtl/c2s_root.sv -----
// ----------------------------------------------------------------------------
// c2s_root
// Pipelined floor square root of 64-bit values, one result bit per stage,
// several lanes side by side with a pass-along bundle.
// ----------------------------------------------------------------------------
`default_nettype none
module c2s_root import c2s_pkg::*; #(
	parameter int LANES = 3,
	parameter int PASS_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [63:0]       in_val [LANES],
	input  wire logic [PASS_W-1:0] in_pass,
	output logic                   out_valid,
	output logic [31:0]            out_root [LANES],
	output logic [PASS_W-1:0]      out_pass
);

	logic              v_s    [0:ROOT_STEPS];
	logic [63:0]       rem_s  [0:ROOT_STEPS][LANES];
	logic [63:0]       res_s  [0:ROOT_STEPS][LANES];
	logic [PASS_W-1:0] pass_s [0:ROOT_STEPS];

	always_comb begin
		v_s[0]    = in_valid;
		pass_s[0] = in_pass;
		for (int l = 0; l < LANES; l++) begin
			rem_s[0][l] = in_val[l];
			res_s[0][l] = '0;
		end
	end

	for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
		logic [63:0] rem_n [LANES];
		logic [63:0] res_n [LANES];
		logic [63:0] trial [LANES];

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				trial[l] = res_s[k][l] + BIT;
				if (rem_s[k][l] >= trial[l]) begin
					rem_n[l] = rem_s[k][l] - trial[l];
					res_n[l] = (res_s[k][l] >> 1) + BIT;
				end else begin
					rem_n[l] = rem_s[k][l];
					res_n[l] = res_s[k][l] >> 1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= rem_n;
			res_s[k+1]  <= res_n;
			pass_s[k+1] <= pass_s[k];
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			out_root[l] = res_s[ROOT_STEPS][l][31:0];
		end
	end

	assign out_valid = v_s[ROOT_STEPS];
	assign out_pass  = pass_s[ROOT_STEPS];

endmodule
`default_nettype wire

// ----- rtl/c2s_cordic.sv -----
// ----------------------------------------------------------------------------
// c2s_cordic
// Pipelined vectoring CORDIC, one micro-rotation per stage, angle out in
// units of 2^-40 degree.
// ----------------------------------------------------------------------------
`default_nettype none
module c2s_cordic import c2s_pkg::*; #(
	parameter int STEPS = CORDIC_STEPS_DEF,
	parameter int LANES = 2,
	parameter int PASS_W = 1
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	input  wire logic signed [LANE_W-1:0] in_x [LANES],
	input  wire logic signed [LANE_W-1:0] in_y [LANES],
	input  wire logic signed [ANG_W-1:0]  in_a [LANES],
	input  wire logic [PASS_W-1:0]       in_pass,
	output logic                         out_valid,
	output logic signed [ANG_W-1:0]      out_a [LANES],
	output logic [PASS_W-1:0]            out_pass
);

	logic                     v_s    [0:STEPS];
	logic signed [LANE_W-1:0] x_s    [0:STEPS][LANES];
	logic signed [LANE_W-1:0] y_s    [0:STEPS][LANES];
	logic signed [ANG_W-1:0]  a_s    [0:STEPS][LANES];
	logic [PASS_W-1:0]        pass_s [0:STEPS];

	always_comb begin
		v_s[0]    = in_valid;
		pass_s[0] = in_pass;
		x_s[0]    = in_x;
		y_s[0]    = in_y;
		a_s[0]    = in_a;
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_rot
		localparam logic signed [ANG_W-1:0] ATAN = atan_entry(i);
		logic signed [LANE_W-1:0] x_n [LANES];
		logic signed [LANE_W-1:0] y_n [LANES];
		logic signed [ANG_W-1:0]  a_n [LANES];

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				if (!y_s[i][l][LANE_W-1] && (y_s[i][l] != '0)) begin
					x_n[l] = x_s[i][l] + (y_s[i][l] >>> i);
					y_n[l] = y_s[i][l] - (x_s[i][l] >>> i);
					a_n[l] = a_s[i][l] + ATAN;
				end else begin
					x_n[l] = x_s[i][l] - (y_s[i][l] >>> i);
					y_n[l] = y_s[i][l] + (x_s[i][l] >>> i);
					a_n[l] = a_s[i][l] - ATAN;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			x_s[i+1]    <= x_n;
			y_s[i+1]    <= y_n;
			a_s[i+1]    <= a_n;
			pass_s[i+1] <= pass_s[i];
		end
	end

	assign out_valid = v_s[STEPS];
	assign out_a     = a_s[STEPS];
	assign out_pass  = pass_s[STEPS];

endmodule
`default_nettype wire

// ----- rtl/c2s_back.sv -----
// ----------------------------------------------------------------------------
// c2s_back
// Angle rounding, wrap and clamp, radius threshold, result register.
// ----------------------------------------------------------------------------
`default_nettype none
module c2s_back import c2s_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	input  wire logic signed [ANG_W-1:0] ra_a,
	input  wire logic signed [ANG_W-1:0] dec_a,
	input  wire logic [31:0]             radius_in,
	input  wire logic [31:0]             speed_in,
	input  wire logic                    xy_zero,
	input  wire logic [31:0]             min_radius,
	output logic                         done,
	output logic                         valid_res,
	output logic [31:0]                  radius,
	output logic [24:0]                  right_ascension,
	output logic signed [23:0]           declination,
	output logic [31:0]                  speed
);

	localparam int SH = INT_FRAC - ANGLE_FRAC_BITS;
	localparam logic signed [ANG_W-1:0] HALF = ANG_W'(1) <<< (SH - 1);
	localparam logic signed [ANG_W-1:0] FULL = ANG_W'(360) <<< ANGLE_FRAC_BITS;
	localparam logic signed [ANG_W-1:0] LIM  = ANG_W'(90) <<< ANGLE_FRAC_BITS;

	logic signed [ANG_W-1:0] ra_r, ra_w, dec_r, dec_c;
	logic                    ok;

	always_comb begin
		ra_r  = (ra_a + HALF) >>> SH;
		dec_r = (dec_a + HALF) >>> SH;
		ra_w  = ra_r;
		if (ra_w < 0) ra_w = ra_w + FULL;
		if (ra_w >= FULL) ra_w = ra_w - FULL;
		if (xy_zero) ra_w = '0;
		dec_c = dec_r;
		if (dec_c > LIM) dec_c = LIM;
		if (dec_c < -LIM) dec_c = -LIM;
		ok = radius_in > min_radius;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		valid_res       <= ok;
		radius          <= ok ? radius_in : '0;
		speed           <= ok ? speed_in : '0;
		right_ascension <= ok ? ra_w[24:0] : '0;
		declination     <= ok ? dec_c[23:0] : '0;
	end

endmodule
`default_nettype wire

// ----- rtl/cartesian_to_spherical.sv -----
// ----------------------------------------------------------------------------
// cartesian_to_spherical
// Position and velocity vectors to radius, right ascension, declination
// and speed.
// ----------------------------------------------------------------------------
// A new beat is taken on every cycle that start is high; busy is always low.
// Each result appears on done for one cycle, after passing through five front
// stages (squares, sums, scaling), 32 square-root stages, one stage per CORDIC
// micro-rotation, and the result register. The output cannot be held off.
// Write min_radius only while no beat is in flight.
// ----------------------------------------------------------------------------
`default_nettype none
module cartesian_to_spherical import c2s_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [31:0] pos_z,
	input  wire logic signed [31:0] vel_x,
	input  wire logic signed [31:0] vel_y,
	input  wire logic signed [31:0] vel_z,
	input  wire logic               min_radius_we,
	input  wire logic [31:0]        min_radius_wdata,
	output logic                    done,
	output logic                    valid_res,
	output logic [31:0]             radius,
	output logic [24:0]             right_ascension,
	output logic signed [23:0]      declination,
	output logic [31:0]             speed
);

	localparam int DONE_LAT = 38 + CORDIC_STEPS;
	localparam int RPASS_W  = 3 * SIDE_W + 2;
	localparam int CPASS_W  = 65;

	logic [31:0] min_radius_q;

	logic                     f_valid, f_neg, f_xyz;
	logic [63:0]              f_pos, f_vel, f_rho;
	logic signed [SIDE_W-1:0] f_cx, f_cy, f_sz;

	logic [63:0]        r_in [3];
	logic [31:0]        r_out [3];
	logic               r_valid;
	logic [RPASS_W-1:0] r_pin, r_pout;

	logic signed [SIDE_W-1:0] q_cx, q_cy, q_sz;
	logic                     q_neg, q_xyz;

	logic signed [LANE_W-1:0] c_x [2];
	logic signed [LANE_W-1:0] c_y [2];
	logic signed [ANG_W-1:0]  c_a [2];
	logic signed [ANG_W-1:0]  c_out [2];
	logic [CPASS_W-1:0]       c_pin, c_pout;
	logic                     c_valid;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_radius_q <= '0;
		end else if (min_radius_we) begin
			min_radius_q <= min_radius_wdata;
		end
	end

	c2s_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.vel_x     (vel_x),
		.vel_y     (vel_y),
		.vel_z     (vel_z),
		.out_valid (f_valid),
		.pos_sum   (f_pos),
		.vel_sum   (f_vel),
		.rho_sum   (f_rho),
		.cx        (f_cx),
		.cy        (f_cy),
		.sz        (f_sz),
		.neg_x     (f_neg),
		.xy_zero   (f_xyz)
	);

	assign r_in[0] = f_pos;
	assign r_in[1] = f_vel;
	assign r_in[2] = f_rho;
	assign r_pin   = {f_cx, f_cy, f_sz, f_neg, f_xyz};

	c2s_root #(
		.LANES  (3),
		.PASS_W (RPASS_W)
	) u_root (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_val    (r_in),
		.in_pass   (r_pin),
		.out_valid (r_valid),
		.out_root  (r_out),
		.out_pass  (r_pout)
	);

	assign {q_cx, q_cy, q_sz, q_neg, q_xyz} = r_pout;

	always_comb begin
		c_x[0] = {{(LANE_W - SIDE_W){q_cx[SIDE_W-1]}}, q_cx} <<< GUARD_BITS;
		c_y[0] = {{(LANE_W - SIDE_W){q_cy[SIDE_W-1]}}, q_cy} <<< GUARD_BITS;
		c_a[0] = q_neg ? (ANG_W'(180) <<< INT_FRAC) : '0;
		c_x[1] = {{(LANE_W - 32){1'b0}}, r_out[2]} <<< GUARD_BITS;
		c_y[1] = {{(LANE_W - SIDE_W){q_sz[SIDE_W-1]}}, q_sz} <<< GUARD_BITS;
		c_a[1] = '0;
	end

	assign c_pin = {r_out[0], r_out[1], q_xyz};

	c2s_cordic #(
		.STEPS  (CORDIC_STEPS),
		.LANES  (2),
		.PASS_W (CPASS_W)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (r_valid),
		.in_x      (c_x),
		.in_y      (c_y),
		.in_a      (c_a),
		.in_pass   (c_pin),
		.out_valid (c_valid),
		.out_a     (c_out),
		.out_pass  (c_pout)
	);

	c2s_back #(
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (c_valid),
		.ra_a            (c_out[0]),
		.dec_a           (c_out[1]),
		.radius_in       (c_pout[64:33]),
		.speed_in        (c_pout[32:1]),
		.xy_zero         (c_pout[0]),
		.min_radius      (min_radius_q),
		.done            (done),
		.valid_res       (valid_res),
		.radius          (radius),
		.right_ascension (right_ascension),
		.declination     (declination),
		.speed           (speed)
	);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##DONE_LAT done)
		else $error("result beat missing at expected latency");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !valid_res) |-> (radius == '0 && speed == '0 &&
			right_ascension == '0 && declination == '0))
		else $error("rejected beat carries nonzero fields");

	a_ra_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (40'(right_ascension) < (40'(360) << ANGLE_FRAC_BITS)))
		else $error("right ascension out of range");

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives position and velocity beats into the cartesian to spherical
// converter, predicts radius, right ascension, declination and speed with a
// bit-exact fixed-point CORDIC model, and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

class spherical_scoreboard;
	typedef struct {
		bit        vld;
		bit [31:0] rad;
		bit [24:0] ra;
		bit [23:0] dec;
		bit [31:0] spd;
	} sph_t;

	sph_t        pending[$];
	longint      atan_deg[32];
	bit   [31:0] min_radius;
	int          errors;

	function new();
		build_atan();
		min_radius = 0;
		errors = 0;
	endfunction

	function void build_atan();
		bit [63:0] pi_q, a, q, r, term;
		int e;
		pi_q = 64'h3243F6A8885A308D;
		for (int i = 0; i < 32; i++) begin
			a = 0;
			q = 0;
			if (i == 0) a = pi_q >> 2;
			else begin
				for (int k = 0; k < 64; k++) begin
					e = i * (2 * k + 1);
					if (e > 60) break;
					term = (64'd1 << (60 - e)) / (2 * k + 1);
					if (k & 1) a -= term;
					else a += term;
				end
			end
			r = a;
			for (int b = 0; b < 50; b++) begin
				r = r << 1;
				q = q << 1;
				if (r >= pi_q) begin
					r -= pi_q;
					q |= 1;
				end
			end
			atan_deg[i] = longint'((q * 180 + 512) >> 10);
		end
	endfunction

	function bit [63:0] root_floor(bit [63:0] v);
		bit [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	function int lead_shift(bit [63:0] m);
		int s;
		s = 0;
		if (m == 0) return 0;
		while ((m << (s + 1)) <= 64'h80000000) s++;
		return s;
	endfunction

	function longint vector_angle(longint x, longint y);
		longint acc, dx, dy;
		acc = 0;
		for (int i = 0; i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx;
				y -= dy;
				acc += atan_deg[i];
			end else begin
				x -= dx;
				y += dy;
				acc -= atan_deg[i];
			end
		end
		return acc;
	endfunction

	function longint round_deg(longint a);
		return (a + (longint'(1) << 23)) >>> 24;
	endfunction

	function bit [63:0] absv(longint v);
		return v < 0 ? -v : v;
	endfunction

	function void note_input(bit [31:0] px, py, pz, vx, vy, vz);
		sph_t o;
		longint x, y, z, cx, cy, base, rr, d, rho, sc;
		bit [63:0] ax, ay, az, m, rad, spd;
		int s;
		x = longint'($signed(px));
		y = longint'($signed(py));
		z = longint'($signed(pz));
		ax = absv(x);
		ay = absv(y);
		az = absv(z);
		rad = root_floor(ax * ax + ay * ay + az * az);
		spd = root_floor(absv($signed(vx)) ** 2 + absv($signed(vy)) ** 2
			+ absv($signed(vz)) ** 2);
		o = '{0, 0, 0, 0, 0};
		if (rad > min_radius) begin
			o.vld = 1;
			o.rad = rad[31:0];
			o.spd = spd[31:0];
			if (ax != 0 || ay != 0) begin
				s = lead_shift(ax > ay ? ax : ay) + 20;
				cx = x <<< s;
				cy = y <<< s;
				base = 0;
				if (cx < 0) begin
					cx = -cx;
					cy = -cy;
					base = longint'(180) << 40;
				end
				rr = round_deg(base + vector_angle(cx, cy));
				if (rr < 0) rr += longint'(360) << 16;
				if (rr >= (longint'(360) << 16)) rr -= longint'(360) << 16;
				o.ra = rr[24:0];
			end
			m = ax > ay ? ax : ay;
			if (az > m) m = az;
			s = lead_shift(m);
			sc = longint'(1) << s;
			rho = longint'(root_floor(absv(x * sc) ** 2 + absv(y * sc) ** 2));
			d = round_deg(vector_angle(rho <<< 20, (z * sc) <<< 20));
			if (d > (longint'(90) << 16)) d = longint'(90) << 16;
			if (d < -(longint'(90) << 16)) d = -(longint'(90) << 16);
			o.dec = d[23:0];
		end
		pending.push_back(o);
	endfunction

	task report(string what, longint got, longint want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		errors++;
	endtask

	task check_result(bit v, bit [31:0] rad, bit [24:0] ra, bit [23:0] dec,
			bit [31:0] spd);
		sph_t e;
		if (pending.size() == 0) begin
			report("unexpected result beat", 1, 0);
			return;
		end
		e = pending.pop_front();
		if (v != e.vld) report("valid_res", v, e.vld);
		if (rad != e.rad) report("radius", rad, e.rad);
		if (ra != e.ra) report("right_ascension", ra, e.ra);
		if (dec != e.dec) report("declination", dec, e.dec);
		if (spd != e.spd) report("speed", spd, e.spd);
	endtask
endclass

module tb;
	import c2s_pkg::*;

	logic               clk, arst_n, start, min_radius_we;
	logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
	logic [31:0]        min_radius_wdata;
	logic               busy, done, valid_res;
	logic [31:0]        radius, speed;
	logic [24:0]        right_ascension;
	logic signed [23:0] declination;

	spherical_scoreboard sb;

	cartesian_to_spherical uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
		.min_radius_we(min_radius_we), .min_radius_wdata(min_radius_wdata),
		.done(done), .valid_res(valid_res), .radius(radius),
		.right_ascension(right_ascension), .declination(declination), .speed(speed)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("CHECKS FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(valid_res, radius, right_ascension, declination, speed);
	end

	task automatic send_beat(bit [31:0] px, py, pz, vx, vy, vz, int gap);
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(negedge clk);
		end
		start <= 1;
		pos_x <= px; pos_y <= py; pos_z <= pz;
		vel_x <= vx; vel_y <= vy; vel_z <= vz;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_input(px, py, pz, vx, vy, vz);
		@(negedge clk);
	endtask

	task automatic drain();
		int n;
		n = 0;
		start <= 0;
		while (sb.pending.size() != 0 && n < 2000) begin
			@(negedge clk);
			n++;
		end
		repeat (80) @(negedge clk);
	endtask

	task automatic set_min_radius(bit [31:0] v);
		drain();
		min_radius_we <= 1;
		min_radius_wdata <= v;
		@(negedge clk);
		min_radius_we <= 0;
		sb.min_radius = v;
	endtask

	function automatic bit [31:0] rand_comp(int mode);
		case (mode)
			0: return $urandom;
			1: return $urandom_range(0, 2000) - 1000;
			2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			default: return $urandom_range(0, 1) ? 0 : $urandom;
		endcase
	endfunction

	task automatic random_beats(int count);
		int m;
		for (int i = 0; i < count; i++) begin
			m = $urandom_range(0, 3);
			send_beat(rand_comp(m), rand_comp(m), rand_comp($urandom_range(0, 3)),
				rand_comp(m), rand_comp(m), rand_comp($urandom_range(0, 3)),
				(i % 100 < 30) ? 0 : $urandom_range(0, 10));
		end
	endtask

	initial begin
		sb = new();
		arst_n = 0;
		start = 0;
		min_radius_we = 0;
		min_radius_wdata = 0;
		{pos_x, pos_y, pos_z, vel_x, vel_y, vel_z} = '0;
		repeat (12) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// directed: zero, axes, extremes, half turn, poles, negative axes
		send_beat(0, 0, 0, 0, 0, 0, 0);
		send_beat(1, 0, 0, 1, 0, 0, 0);
		send_beat(0, 1, 0, 0, 1, 0, 0);
		send_beat(-1, 0, 0, 0, 0, -1, 1);
		send_beat(0, -1, 0, -5, 3, 2, 0);
		send_beat(0, 0, 5, 0, 0, 0, 0);
		send_beat(0, 0, -5, 0, 0, 0, 2);
		send_beat(-1, -1, 0, 7, 7, 7, 0);
		send_beat(-7, 1, 0, 0, 0, 0, 0);
		send_beat(1000, -1, 3, 0, 0, 0, 0);
		send_beat(32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000, 0);
		send_beat(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
		send_beat(32'h80000000, 0, 0, 32'hffffffff, 0, 0, 3);
		send_beat(32'h7fffffff, 32'h80000000, 1, 0, 32'h80000000, 0, 0);
		send_beat(-1, 32'hffffffff, 32'h7fffffff, 1, 1, 1, 0);
		send_beat(32'h80000000, -1, 0, 0, 0, 0, 0);
		set_min_radius(5);
		send_beat(3, 4, 0, 1, 1, 1, 0);
		send_beat(3, 4, 1, 1, 1, 1, 0);
		send_beat(0, 0, 6, 0, 0, 0, 0);
		random_beats(300);
		set_min_radius(32'hffffffff);
		send_beat(32'h80000000, 32'h80000000, 32'h80000000, 1, 2, 3, 0);
		random_beats(100);
		set_min_radius(32'h7fffffff);
		random_beats(250);
		set_min_radius(0);
		random_beats(500);
		// hold off until the pipeline is empty, then continue
		drain();
		set_min_radius($urandom_range(0, 2000));
		random_beats(280);
		drain();
		if (sb.pending.size() != 0)
			sb.report("results never arrived", 0, sb.pending.size());
		if (sb.errors == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end
endmodule
`default_nettype wire
